// File: rtl/mh2_pkg.sv
// mh2_pkg: shared types, constants and helpers for the streaming murmurhash2 block
// used by mh2_ctrl, mh2_datapath and the top level; no dependencies

package mh2_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned NbW   = 3;
  localparam int unsigned InW   = 72;  // 67 payload bits padded to whole bytes

  localparam logic [WordW-1:0] MurM = 32'h5bd1e995;
  localparam int unsigned MurR  = 24;
  localparam int unsigned AvSh1 = 13;
  localparam int unsigned AvSh2 = 15;

  localparam logic [NbW-1:0] NbNone = 3'd0;
  localparam logic [NbW-1:0] NbFull = 3'd4;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_HMIX,
    ST_TAIL,
    ST_AV,
    ST_OUT
  } state_e;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_K_MUL1,
    OP_K_MUL2,
    OP_H_MIX,
    OP_TAIL,
    OP_AV,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic sel_len;  // on load: seed hash from the length field
  } cmd_t;

  // byte mask of the valid part of a word, counts above four saturate
  function automatic logic [WordW-1:0] byte_mask(input logic [NbW-1:0] nb);
    logic [WordW-1:0] m;
    case (nb)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/mh2_datapath.sv
// mh2_datapath: hash and key registers around one shared multiply-by-m unit
// plus the output register; depends on mh2_pkg

module mh2_datapath (
  input  logic                      clk_i,
  input  mh2_pkg::cmd_t             cmd_i,
  input  logic [mh2_pkg::WordW-1:0] data_word_i,
  input  logic [mh2_pkg::NbW-1:0]   valid_bytes_i,
  input  logic [mh2_pkg::WordW-1:0] total_length_i,
  output logic [mh2_pkg::WordW-1:0] hash_value_o
);
  import mh2_pkg::*;

  logic [WordW-1:0]   h_q, h_d;
  logic [WordW-1:0]   k_q, k_d;
  logic [WordW-1:0]   res_q, res_d;
  logic [WordW-1:0]   mul_a;
  logic [WordW-1:0]   prod;

  // operand select for the shared multiplier
  always_comb begin
    case (cmd_i.op)
      OP_K_MUL2: mul_a = k_q ^ (k_q >> MurR);
      OP_H_MIX:  mul_a = h_q;
      OP_TAIL:   mul_a = h_q ^ k_q;
      OP_AV:     mul_a = h_q ^ (h_q >> AvSh1);
      default:   mul_a = k_q;
    endcase
  end

  // only the low word of the product is kept
  assign prod = mul_a * MurM;

  always_comb begin
    h_d   = h_q;
    k_d   = k_q;
    res_d = res_q;
    case (cmd_i.op) inside
      OP_LOAD: begin
        h_d = cmd_i.sel_len ? total_length_i : h_q;
        k_d = data_word_i & byte_mask(valid_bytes_i);
      end
      OP_K_MUL1, OP_K_MUL2: k_d = prod;
      OP_H_MIX:             h_d = prod ^ k_q;
      OP_TAIL, OP_AV:       h_d = prod;
      OP_OUT:               res_d = h_q ^ (h_q >> AvSh2);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    k_q   <= k_d;
    res_q <= res_d;
  end

  assign hash_value_o = res_q;

endmodule

// File: rtl/mh2_ctrl.sv
// mh2_ctrl: sequencer for one item at a time and the output valid flag
// depends on mh2_pkg; drives mh2_datapath through cmd_t

module mh2_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    first_i,
  input  logic                    last_i,
  input  logic [mh2_pkg::NbW-1:0] valid_bytes_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output mh2_pkg::cmd_t           cmd_o
);
  import mh2_pkg::*;

  state_e state_q, state_d;
  logic   in_msg_q, in_msg_d;
  logic   last_q, last_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc, take, out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign take       = in_acc && (first_i || in_msg_q);
  assign out_free   = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      ST_IDLE: begin
        if (take) begin
          if (valid_bytes_i >= NbFull) state_d = ST_K1;
          else if (valid_bytes_i != NbNone) state_d = ST_TAIL;
          else if (last_i) state_d = ST_AV;
          else state_d = ST_IDLE;
        end
      end
      ST_K1:   state_d = ST_K2;
      ST_K2:   state_d = ST_HMIX;
      ST_HMIX, ST_TAIL: begin
        state_d = last_q ? ST_AV : ST_IDLE;
      end
      ST_AV:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and flags
  always_comb begin
    cmd_o.op      = OP_NONE;
    cmd_o.sel_len = first_i;
    in_msg_d      = in_msg_q;
    last_d        = last_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          cmd_o.op = OP_LOAD;
          in_msg_d = 1'b1;
          last_d   = last_i;
        end
      end
      ST_K1:   cmd_o.op = OP_K_MUL1;
      ST_K2:   cmd_o.op = OP_K_MUL2;
      ST_HMIX: cmd_o.op = OP_H_MIX;
      ST_TAIL: cmd_o.op = OP_TAIL;
      ST_AV:   cmd_o.op = OP_AV;
      ST_OUT: begin
        if (out_free) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          in_msg_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_msg_q    <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_msg_q    <= in_msg_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/murmur2_hash32_stream_top.sv
// murmur2_hash32_stream_top: streaming 32-bit murmurhash2, seed 0
// depends on mh2_pkg, mh2_ctrl and mh2_datapath
//
// usage
// - slave channel carries one message word per transfer, first byte in the
//   low bits; tuser marks the first word (hash seeded with total_length),
//   tlast marks the last word, after which one hash transfer follows
// - a word with one to three valid bytes is mixed as a tail
// - words that arrive with no open message and no first flag are dropped
// - master channel carries the finished 32-bit hash
// timing
// - all multiplies by m go through one shared 32x32 multiplier, one per
//   cycle, so a full word passes through load, K1, K2 and HMIX, a tail
//   through load and TAIL, a word with no bytes only through load, and
//   the last item adds AV and OUT
// - after the last word, OUT waits until the output register is free,
//   then loads the hash and sets the valid flag
// - the hash sits in an output register; a stalled receiver holds the block
//   only when a second hash is finished before the first has been taken
// reset
// - rst_ni is asynchronous, active low; no message is open afterward and
//   the master channel shows no transfer

module murmur2_hash32_stream_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // data_word[31:0], valid_bytes[34:32],
                                     // total_length[66:35], zeros[71:67]
  input  logic [0:0]  s_axis_tuser,  // first_item[0]
  input  logic        s_axis_tlast,  // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // hash_value[31:0]
);
  import mh2_pkg::*;

  cmd_t             cmd;
  logic [WordW-1:0] data_word;
  logic [NbW-1:0]   valid_bytes;
  logic [WordW-1:0] total_length;

  // unpack the slave payload
  assign data_word    = s_axis_tdata[31:0];
  assign valid_bytes  = s_axis_tdata[34:32];
  assign total_length = s_axis_tdata[66:35];

  mh2_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .first_i       (s_axis_tuser[0]),
    .last_i        (s_axis_tlast),
    .valid_bytes_i (valid_bytes),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .cmd_o         (cmd)
  );

  mh2_datapath u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .data_word_i    (data_word),
    .valid_bytes_i  (valid_bytes),
    .total_length_i (total_length),
    .hash_value_o   (m_axis_tdata)
  );

endmodule

// File: rtl/mh2_checker.sv
// mh2_checker: port-level assertions for murmur2_hash32_stream_top
// attached by the bind statement at the end; no package dependency

module mh2_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [71:0] s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // a held hash stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled hash transfer changed");

  // a first word with bytes keeps the block busy on the next cycle
  a_busy_after_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && (s_axis_tdata[34:32] != 3'd0)
    |=> !s_axis_tready)
    else $error("block ready right after a word with bytes");

  // a new hash is only produced while the input side is closed
  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("hash appeared straight out of idle");

  // no output transfer is offered during reset recovery
  a_reset_quiet: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("hash valid right after reset");

endmodule

bind murmur2_hash32_stream_top mh2_checker u_mh2_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
